// ----- rtl/cbear_pkg.sv -----
// Shared types, widths and constants of the clockwise bearing block.
package cbear_pkg;

  // Iteration count, capped at the arctangent table length.
  localparam int unsigned ITERATIONS  = 16;
  localparam int unsigned TABLE_LEN   = 24;
  localparam int unsigned N_ITER      = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

  // Coordinate field width and the part of it that carries the coordinate.
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned CW_EFF      = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int unsigned DW          = CW_EFF + 1;        // exact difference width
  localparam int unsigned GUARD       = 24;
  localparam int unsigned XW          = DW + GUARD + 2;    // magnitude, gain growth, sign
  localparam int unsigned ZW          = 32;                // degrees, 24 fraction bits
  localparam int unsigned SHW         = $clog2(TABLE_LEN);

  // Angle rounding: degrees * 2^24 down to 1/128 degree.
  localparam int unsigned ROUND_SHIFT = 17;
  localparam int unsigned QW          = ZW - ROUND_SHIFT;
  localparam int unsigned THW         = 14;
  localparam logic [ZW-1:0] Z_MAX     = ZW'(90) << GUARD;
  localparam logic [ZW-1:0] Z_HALF    = ZW'(1) << (ROUND_SHIFT - 1);

  // Bearing constants in 1/128 degree.
  localparam int unsigned BW          = 16;
  localparam logic [BW-1:0] FULL_TURN     = 16'd46080;
  localparam logic [BW-1:0] HALF_TURN     = 16'd23040;
  localparam logic [BW-1:0] QUARTER       = 16'd11520;
  localparam logic [BW-1:0] THREE_QUARTER = 16'd34560;

  // Output queue.
  localparam int unsigned FIFO_DEPTH  = 32;
  localparam int unsigned PTRW        = $clog2(FIFO_DEPTH);
  localparam int unsigned CNTW        = PTRW + 1;

  // atan(2^-i) in degrees * 2^24, rounded to nearest.
  localparam logic [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  // Direction class of the difference vector.
  typedef enum logic [3:0] {
    KIND_EQUAL = 4'd0,
    KIND_POS_X = 4'd1,
    KIND_NEG_X = 4'd2,
    KIND_POS_Y = 4'd3,
    KIND_NEG_Y = 4'd4,
    KIND_PXNY  = 4'd5,
    KIND_NXNY  = 4'd6,
    KIND_NXPY  = 4'd7,
    KIND_PXPY  = 4'd8
  } kind_e;

  typedef struct packed {
    logic  vld;
    kind_e kind;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [FIELD_W-1:0] start_x;
    logic [FIELD_W-1:0] start_y;
    logic [FIELD_W-1:0] end_x;
    logic [FIELD_W-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic [BW-1:0] bearing;
    logic          points_equal;
  } out_t;

endpackage

// ----- rtl/cbear_prep.sv -----
// Front end: coordinate differences, magnitudes and direction class.
module cbear_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  cbear_pkg::in_t    data_i,
  output cbear_pkg::side_t  side_o,
  output cbear_pkg::cordic_t data_o
);

  localparam int unsigned DW    = cbear_pkg::DW;
  localparam int unsigned CW    = cbear_pkg::CW_EFF;
  localparam int unsigned XW    = cbear_pkg::XW;
  localparam int unsigned GUARD = cbear_pkg::GUARD;

  logic          vld1_q;
  logic [DW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [DW-1:0] ax, ay;
  cbear_pkg::kind_e kind;
  cbear_pkg::side_t side_q;
  cbear_pkg::cordic_t data_q;

  // Sign-extend each coordinate by one bit, then subtract exactly.
  assign dx_d = {data_i.end_x[CW-1], data_i.end_x[CW-1:0]}
              - {data_i.start_x[CW-1], data_i.start_x[CW-1:0]};
  assign dy_d = {data_i.end_y[CW-1], data_i.end_y[CW-1:0]}
              - {data_i.start_y[CW-1], data_i.start_y[CW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  // Magnitudes fit unsigned in DW bits, the most negative difference too.
  assign ax = dx_q[DW-1] ? (~dx_q + DW'(1)) : dx_q;
  assign ay = dy_q[DW-1] ? (~dy_q + DW'(1)) : dy_q;

  always_comb begin
    priority if (dx_q == '0 && dy_q == '0) begin
      kind = cbear_pkg::KIND_EQUAL;
    end else if (dy_q == '0) begin
      kind = dx_q[DW-1] ? cbear_pkg::KIND_NEG_X : cbear_pkg::KIND_POS_X;
    end else if (dx_q == '0) begin
      kind = dy_q[DW-1] ? cbear_pkg::KIND_NEG_Y : cbear_pkg::KIND_POS_Y;
    end else if (!dx_q[DW-1] && dy_q[DW-1]) begin
      kind = cbear_pkg::KIND_PXNY;
    end else if (dx_q[DW-1] && dy_q[DW-1]) begin
      kind = cbear_pkg::KIND_NXNY;
    end else if (dx_q[DW-1]) begin
      kind = cbear_pkg::KIND_NXPY;
    end else begin
      kind = cbear_pkg::KIND_PXPY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '{vld: 1'b0, kind: cbear_pkg::KIND_EQUAL};
    end else begin
      side_q <= '{vld: vld1_q, kind: kind};
    end
  end

  always_ff @(posedge clk_i) begin
    data_q.x <= {{(XW-DW-GUARD){1'b0}}, ax, {GUARD{1'b0}}};
    data_q.y <= {{(XW-DW-GUARD){1'b0}}, ay, {GUARD{1'b0}}};
    data_q.z <= '0;
  end

  assign side_o = side_q;
  assign data_o = data_q;

endmodule

// ----- rtl/cbear_cell.sv -----
// One vectoring step of the CORDIC chain, registered.
module cbear_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cbear_pkg::SHW-1:0]     shift_i,
  input  logic [cbear_pkg::ZW-1:0]      angle_i,
  input  cbear_pkg::side_t              side_i,
  input  cbear_pkg::cordic_t            data_i,
  output cbear_pkg::side_t              side_o,
  output cbear_pkg::cordic_t            data_o
);

  localparam int unsigned XW = cbear_pkg::XW;
  localparam int unsigned ZW = cbear_pkg::ZW;

  logic signed [XW-1:0] x, y, xs, ys;
  logic signed [ZW-1:0] z, ang;
  cbear_pkg::cordic_t   data_d, data_q;
  cbear_pkg::side_t     side_q;

  assign x   = data_i.x;
  assign y   = data_i.y;
  assign z   = data_i.z;
  assign ang = $signed(angle_i);
  assign xs  = x >>> shift_i;
  assign ys  = y >>> shift_i;

  // Rotate toward the x axis: the sign of y picks the direction.
  always_comb begin
    if (!y[XW-1]) begin
      data_d.x = x + ys;
      data_d.y = y - xs;
      data_d.z = z + ang;
    end else begin
      data_d.x = x - ys;
      data_d.y = y + xs;
      data_d.z = z - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '{vld: 1'b0, kind: cbear_pkg::KIND_EQUAL};
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign side_o = side_q;
  assign data_o = data_q;

endmodule

// ----- rtl/cbear_post.sv -----
// Back end: clamp and round the angle, then map it onto a bearing.
module cbear_post (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cbear_pkg::side_t          side_i,
  input  logic [cbear_pkg::ZW-1:0]  z_i,
  output logic                      vld_o,
  output cbear_pkg::out_t           data_o
);

  localparam int unsigned ZW  = cbear_pkg::ZW;
  localparam int unsigned QW  = cbear_pkg::QW;
  localparam int unsigned THW = cbear_pkg::THW;
  localparam int unsigned BW  = cbear_pkg::BW;

  logic [ZW-1:0]    zc, zr;
  logic [QW-1:0]    q;
  logic [THW-1:0]   theta_d, theta_q;
  logic [BW-1:0]    th16;
  cbear_pkg::side_t side_q;
  logic             vld_q;
  cbear_pkg::out_t  res_d, res_q;

  // Clamp to [0, 90 deg], round half up to 1/128 degree.
  always_comb begin
    priority if (z_i[ZW-1]) begin
      zc = '0;
    end else if (z_i > cbear_pkg::Z_MAX) begin
      zc = cbear_pkg::Z_MAX;
    end else begin
      zc = z_i;
    end
  end

  assign zr      = zc + cbear_pkg::Z_HALF;
  assign q       = zr[ZW-1:cbear_pkg::ROUND_SHIFT];
  assign theta_d = (BW'(q) > cbear_pkg::QUARTER) ? THW'(cbear_pkg::QUARTER) : THW'(q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '{vld: 1'b0, kind: cbear_pkg::KIND_EQUAL};
      vld_q  <= 1'b0;
    end else begin
      side_q <= side_i;
      vld_q  <= side_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    theta_q <= theta_d;
    res_q   <= res_d;
  end

  assign th16 = BW'(theta_q);

  always_comb begin
    res_d.points_equal = 1'b0;
    unique case (side_q.kind)
      cbear_pkg::KIND_EQUAL: begin
        res_d.bearing      = '0;
        res_d.points_equal = 1'b1;
      end
      cbear_pkg::KIND_POS_X: res_d.bearing = '0;
      cbear_pkg::KIND_NEG_X: res_d.bearing = cbear_pkg::HALF_TURN;
      cbear_pkg::KIND_POS_Y: res_d.bearing = cbear_pkg::THREE_QUARTER;
      cbear_pkg::KIND_NEG_Y: res_d.bearing = cbear_pkg::QUARTER;
      cbear_pkg::KIND_PXNY:  res_d.bearing = th16;
      cbear_pkg::KIND_NXNY:  res_d.bearing = cbear_pkg::HALF_TURN - th16;
      cbear_pkg::KIND_NXPY:  res_d.bearing = cbear_pkg::HALF_TURN + th16;
      // a full turn wraps to zero
      cbear_pkg::KIND_PXPY:  res_d.bearing = (th16 == '0) ? '0 : cbear_pkg::FULL_TURN - th16;
      default:               res_d.bearing = '0;
    endcase
  end

  assign vld_o  = vld_q;
  assign data_o = res_q;

endmodule

// ----- rtl/cbear_fifo.sv -----
// Output queue that absorbs results while the consumer stalls.
module cbear_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cbear_pkg::out_t  push_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cbear_pkg::out_t  out_data_o
);

  localparam int unsigned PTRW = cbear_pkg::PTRW;
  localparam int unsigned CNTW = cbear_pkg::CNTW;

  cbear_pkg::out_t mem_q [cbear_pkg::FIFO_DEPTH];
  logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;
  logic            pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTRW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTRW'(1);
      end
      count_q <= count_q + CNTW'(push_i) - CNTW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/clockwise_bearing_angle_top.sv -----
// Pipeline from input beat to output valid: 2 front stages, 16 CORDIC steps, 2 back stages, 1 queue register.
// Throughput: one beat per cycle while in_ready_o is high, set by the unrolled chain of registered CORDIC steps.
// A 32-entry output queue with an in-flight count decouples the two sides; input stalls
// whenever 32 results are in flight or queued, even in a cycle where the consumer takes one.
// Reset: asynchronous active low; clears all valid bits, the queue and the in-flight count.
// Top level of the clockwise bearing angle block.
module clockwise_bearing_angle_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cbear_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cbear_pkg::out_t  out_data_o
);

  localparam int unsigned N_ITER = cbear_pkg::N_ITER;
  localparam int unsigned CNTW   = cbear_pkg::CNTW;

  logic               in_acc, out_acc;
  logic [CNTW-1:0]    inflight_q;

  // Chain links: entry k feeds step k, entry N_ITER is the chain output.
  cbear_pkg::side_t   side_c [N_ITER+1];
  cbear_pkg::cordic_t data_c [N_ITER+1];

  logic               res_vld;
  cbear_pkg::out_t    res_data;

  // Count beats accepted but not yet delivered; the queue can always hold them.
  assign in_ready_o = (inflight_q != CNTW'(cbear_pkg::FIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CNTW'(in_acc) - CNTW'(out_acc);
    end
  end

  // Form differences, classify the direction and load the CORDIC operands.
  cbear_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_acc),
    .data_i (in_data_i),
    .side_o (side_c[0]),
    .data_o (data_c[0])
  );

  // Advance the vector one rotation per step; each step has its own shift and angle.
  for (genvar k = 0; k < N_ITER; k++) begin : g_step
    cbear_cell u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (cbear_pkg::SHW'(k)),
      .angle_i (cbear_pkg::ATAN_TAB[k]),
      .side_i  (side_c[k]),
      .data_i  (data_c[k]),
      .side_o  (side_c[k+1]),
      .data_o  (data_c[k+1])
    );
  end

  // Round the angle and place it in its quadrant; axis cases bypass the angle.
  cbear_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side_c[N_ITER]),
    .z_i    (data_c[N_ITER].z),
    .vld_o  (res_vld),
    .data_o (res_data)
  );

  // Hold results until the consumer takes them.
  cbear_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .push_data_i (res_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
